// ----- hdl/bebe_pkg.sv -----
// ----------------------------------------------------------------------------
// bebe_pkg
// Shared constants, types and helpers for the binary erosion boundary block.
// ----------------------------------------------------------------------------
package bebe_pkg;

  // Image geometry.
  localparam int IMAGE_WIDTH  = 512;
  localparam int IMAGE_HEIGHT = 512;

  // Position counters: the row counter also holds the flush row index.
  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT + 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_FLUSH = ROW_W'(IMAGE_HEIGHT);

  // Field widths of the stream items.
  localparam int PIX_W = 8;
  localparam int POS_W = 9;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  // Stream bus widths.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = '0;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd125;

  // Row buffer memory: bit 0 holds row r-2, bit 1 holds row r-1.
  localparam int LINE_W = 2;

  // Result queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One accepted item on its way to the window stage.
  typedef struct packed {
    logic             pix_bit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } stage_t;

  // One result item.
  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_column;
    logic [PIX_W-1:0] binary_pixel;
    logic [PIX_W-1:0] eroded_pixel;
    logic [PIX_W-1:0] boundary_pixel;
    logic             last_of_run;
    logic             end_of_frame;
  } result_t;

  // Up to two results pushed by one item; the second only follows the first.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  // Map a binary bit onto its grey level.
  function automatic logic [PIX_W-1:0] to_level(input logic b);
    return b ? PIX_WHITE : PIX_BLACK;
  endfunction

endpackage

// ----- hdl/bebe_ram.sv -----
// ----------------------------------------------------------------------------
// bebe_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bebe_ram #(
  parameter int DEPTH  = 512,
  parameter int WIDTH  = 2,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/bebe_win.sv -----
// ----------------------------------------------------------------------------
// bebe_win
// 3x3 window stage: merges the row buffer read with the new binary pixel,
// writes the shifted rows back and forms up to two erosion results.
// ----------------------------------------------------------------------------
module bebe_win (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  bebe_pkg::stage_t          s1,
  input  logic [bebe_pkg::LINE_W-1:0] rd_data,
  output logic                      wr_en,
  output logic [bebe_pkg::COL_W-1:0] wr_addr,
  output logic [bebe_pkg::LINE_W-1:0] wr_data,
  output bebe_pkg::push_t           push
);
  import bebe_pkg::*;

  logic [8:0] window_r, window_nxt;
  logic       fill_done_r, fill_done_nxt;
  logic       top, mid;
  logic [2:0] row_ok;
  logic [2:0] col_ok_a, col_ok_b;
  logic       cen_a, cen_b, ero_a, ero_b;
  logic       row_ge1;

  // Eroded value of a centre bit over the permitted window positions.
  function automatic logic erode(input logic [8:0] w, input logic centre,
                                 input logic [2:0] rok, input logic [2:0] cok);
    logic e;
    e = centre;
    for (int wr = 0; wr < 3; wr++) begin
      for (int wc = 0; wc < 3; wc++) begin
        if (rok[wr] && cok[wc] && !w[wr*3 + wc]) begin
          e = 1'b0;
        end
      end
    end
    return e;
  endfunction

  // Until the first row after reset has been written, the buffers read white.
  always_comb begin
    top = fill_done_r ? rd_data[0] : 1'b1;
    mid = fill_done_r ? rd_data[1] : 1'b1;
    window_nxt = {s1.pix_bit, window_r[8:7], mid, window_r[5:4], top, window_r[2:1]};
    fill_done_nxt = fill_done_r | (s1_valid && (s1.col == COL_LAST));
  end

  // Write back: row r-1 moves up, the new bit becomes row r-1.
  assign wr_en   = s1_valid;
  assign wr_addr = s1.col;
  assign wr_data = {s1.pix_bit, mid};

  // Window rows outside the image are ignored, as are columns left of 0
  // and right of the last column.
  always_comb begin
    row_ok   = {(s1.row < ROW_FLUSH), 1'b1, (s1.row >= ROW_W'(2))};
    col_ok_a = {1'b1, 1'b1, (s1.col >= COL_W'(2))};
    col_ok_b = 3'b011 << 1;
    cen_a    = window_nxt[4];
    cen_b    = window_nxt[5];
    ero_a    = erode(window_nxt, cen_a, row_ok, col_ok_a);
    ero_b    = erode(window_nxt, cen_b, row_ok, col_ok_b);
    row_ge1  = (s1.row != '0);
  end

  // Result for the centre one column back, and at a row end also the last
  // column of the row above.
  always_comb begin
    push.v0 = s1_valid && row_ge1 && (s1.col != '0);
    push.v1 = s1_valid && row_ge1 && (s1.col == COL_LAST);

    push.r0.out_row        = POS_W'(s1.row - ROW_W'(1));
    push.r0.out_column     = POS_W'(s1.col - COL_W'(1));
    push.r0.binary_pixel   = to_level(cen_a);
    push.r0.eroded_pixel   = to_level(ero_a);
    push.r0.boundary_pixel = to_level(cen_a & ~ero_a);
    push.r0.last_of_run    = !push.v1;
    push.r0.end_of_frame   = 1'b0;

    push.r1.out_row        = POS_W'(s1.row - ROW_W'(1));
    push.r1.out_column     = POS_W'(s1.col);
    push.r1.binary_pixel   = to_level(cen_b);
    push.r1.eroded_pixel   = to_level(ero_b);
    push.r1.boundary_pixel = to_level(cen_b & ~ero_b);
    push.r1.last_of_run    = 1'b1;
    push.r1.end_of_frame   = (s1.row == ROW_FLUSH);
  end

  // Window and fill mark.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= 9'h1FF;
      fill_done_r <= 1'b0;
    end else begin
      if (s1_valid) begin
        window_r <= window_nxt;
      end
      fill_done_r <= fill_done_nxt;
    end
  end

endmodule

// ----- hdl/bebe_fifo.sv -----
// ----------------------------------------------------------------------------
// bebe_fifo
// Result queue taking up to two items a cycle and giving one.
// ----------------------------------------------------------------------------
module bebe_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bebe_pkg::push_t               push,
  input  logic                          pop,
  output bebe_pkg::result_t             head,
  output logic                          not_empty,
  output logic [bebe_pkg::FIFO_CNT_W-1:0] count
);
  import bebe_pkg::*;

  result_t                slot [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]  count_r, count_nxt;
  logic [FIFO_PTR_W-1:0]  second_ptr;

  // Pointer and fill arithmetic.
  always_comb begin
    second_ptr = wr_ptr_r + FIFO_PTR_W'(push.v0);
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.v0) + FIFO_PTR_W'(push.v1);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1)
                 - FIFO_CNT_W'(pop);
  end

  // Storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push.v0) begin
      slot[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      slot[second_ptr] <= push.r1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head      = slot[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

// ----- hdl/binary_erosion_boundary_extract.sv -----
// ----------------------------------------------------------------------------
// binary_erosion_boundary_extract
// Thresholds a raster pixel stream, erodes it with a 3x3 square and gives the
// binary, eroded and boundary images, one row and one column behind.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Carries
//  in_      slave      tvalid/tready       grey pixel, padding flag
//  out_     master     tvalid/tready       position, binary, eroded, boundary
//  cfg_     APB slave  psel/penable/pready threshold register at address 0
//
// One item is taken per cycle; the row buffer RAM is read on acceptance and
// written back the next cycle, so the window stage keeps pace with the input.
// A row-end item yields two results, so the result queue drains them at one a
// cycle while out_tready is high; input is held off only near a full queue.
// After reset the row buffers read white through the first row; there is no
// clearing pass. A stalled output keeps its item until it is taken.
// ----------------------------------------------------------------------------
module binary_erosion_boundary_extract (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: pixel_in[7:0]
  input  logic [bebe_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: is_padding[0]
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: out_row[8:0], out_column[17:9], binary_pixel[25:18],
  //            eroded_pixel[33:26], boundary_pixel[41:34], zeros[47:42]
  output logic [bebe_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: end_of_frame[0]
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [bebe_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [bebe_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [bebe_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import bebe_pkg::*;

  logic [PIX_W-1:0]      threshold_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  s1_valid_r;
  stage_t                s1_r, s1_nxt;
  logic                  in_acc;
  logic [LINE_W-1:0]     rd_data;
  logic                  wr_en;
  logic [COL_W-1:0]      wr_addr;
  logic [LINE_W-1:0]     wr_data;
  push_t                 push;
  result_t               head;
  logic                  not_empty;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   committed;
  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  reg_idx;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_idx == REG_THRESHOLD) ? CFG_DATA_W'(threshold_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr && (reg_idx == REG_THRESHOLD)) begin
      threshold_r <= cfg_pwdata[PIX_W-1:0];
    end
  end

  // Room is reserved for two results from the item in the window stage and
  // two more from the item being accepted.
  assign committed = {1'b0, fifo_count} + {{(FIFO_CNT_W-1){1'b0}}, s1_valid_r, 1'b0};
  assign in_tready = (committed <= (FIFO_CNT_W+1)'(FIFO_DEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;

  // Threshold and raster position of the accepted item.
  always_comb begin
    s1_nxt.row     = row_r;
    s1_nxt.col     = col_r;
    s1_nxt.pix_bit = (row_r >= ROW_FLUSH) || in_tuser ||
                     (in_tdata[PIX_W-1:0] >= threshold_r);
    if (col_r == COL_LAST) begin
      col_nxt = '0;
      row_nxt = (row_r >= ROW_FLUSH) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Row buffers. Consecutive items hit different columns, so the write of one
  // item never meets the read of the next at the same entry.
  bebe_ram #(
    .DEPTH  (IMAGE_WIDTH),
    .WIDTH  (LINE_W),
    .ADDR_W (COL_W)
  ) u_line (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Window stage.
  bebe_win u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1       (s1_r),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push)
  );

  // Result queue.
  bebe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tvalid && out_tready),
    .head      (head),
    .not_empty (not_empty),
    .count     (fifo_count)
  );

  // Output packing.
  assign out_tvalid = not_empty;
  assign out_tlast  = head.last_of_run;
  assign out_tuser  = head.end_of_frame;
  assign out_tdata  = {6'b0, head.boundary_pixel, head.eroded_pixel, head.binary_pixel,
                       head.out_column, head.out_row};

endmodule

// ----- hdl/bebe_checker.sv -----
// ----------------------------------------------------------------------------
// bebe_checker
// Port-level checks on the result stream of the boundary extraction block.
// ----------------------------------------------------------------------------
module bebe_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic [bebe_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready
);
  import bebe_pkg::*;

  localparam logic [POS_W-1:0] LAST_COL = POS_W'(IMAGE_WIDTH - 1);
  localparam logic [POS_W-1:0] PREV_COL = POS_W'(IMAGE_WIDTH - 2);
  localparam logic [POS_W-1:0] LAST_ROW = POS_W'(IMAGE_HEIGHT - 1);

  logic [POS_W-1:0] col_f, row_f;
  logic [PIX_W-1:0] bin_f, ero_f, bnd_f;

  assign row_f = out_tdata[8:0];
  assign col_f = out_tdata[17:9];
  assign bin_f = out_tdata[25:18];
  assign ero_f = out_tdata[33:26];
  assign bnd_f = out_tdata[41:34];

  // A stalled item holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                 $stable(out_tlast) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // The frame's final pixel closes its run and sits at the bottom right.
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (col_f == LAST_COL) && (row_f == LAST_ROW))
    else $error("end of frame on a wrong result");

  // Only a row end gives two results, and the first is the next-to-last column.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (col_f == PREV_COL) && !out_tuser)
    else $error("unexpected result that does not close its run");

  // Boundary is binary minus eroded, and erosion never whitens a pixel.
  a_bnd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (bnd_f == (bin_f & ~ero_f)) && ((ero_f & ~bin_f) == PIX_BLACK))
    else $error("boundary inconsistent with binary and eroded pixels");

endmodule

bind binary_erosion_boundary_extract bebe_checker u_bebe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ----- tb/sv/boundary_checker.sv -----
// ----------------------------------------------------------------------------
// boundary_checker
// Watches the pixel, result and register channels of the erosion boundary
// block. It keeps its own copy of the threshold, the two binary row buffers,
// the 3x3 window and the raster position. For every accepted pixel item it
// works out the binary, eroded and boundary results and queues them. It then
// compares every accepted result item field by field with the oldest one
// waiting.
// ----------------------------------------------------------------------------
module boundary_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [bebe_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [bebe_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 out_tuser,
  input  logic                                 out_tlast,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [bebe_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [bebe_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  input  logic                                 cfg_pready,
  output int                                   error_count,
  output int                                   results_due,
  output int                                   results_checked,
  output int                                   frames_done
);

  import bebe_pkg::*;

  // Window column of the centre pixel: one behind the newest column, or the
  // newest column itself for the extra result at the end of a row.
  localparam int CENTRE_LAG  = 1;
  localparam int CENTRE_EDGE = 2;

  // Bit offsets of the fields in out_tdata.
  localparam int ROW_LSB  = 0;
  localparam int COL_LSB  = ROW_LSB + POS_W;
  localparam int BIN_LSB  = COL_LSB + POS_W;
  localparam int ERO_LSB  = BIN_LSB + PIX_W;
  localparam int BND_LSB  = ERO_LSB + PIX_W;

  // Own copy of the block's state.
  logic [PIX_W-1:0]       grey_threshold;
  logic [IMAGE_WIDTH-1:0] line_older;
  logic [IMAGE_WIDTH-1:0] line_newer;
  logic [8:0]             window;
  logic [ROW_W-1:0]       raster_row;
  logic [COL_W-1:0]       raster_col;

  // Boundary results that are still to come out of the block.
  result_t boundary_due[$];

  // Erode the centre at window column k; the pixel item that caused it sits
  // at (r, c). Neighbours outside the image count as white.
  function automatic result_t erode_centre(input logic [8:0] win,
                                           input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c,
                                           input int k);
    result_t res;
    logic    centre;
    logic    kept;
    int      wr;
    int      wc;
    centre = win[3 + k];
    kept   = centre;
    if (centre) begin
      for (wr = 0; wr < 3; wr++) begin
        if (wr == 0 && r < 2) continue;
        if (wr == 2 && r >= ROW_FLUSH) continue;
        for (wc = k - 1; wc <= k + 1; wc++) begin
          if (wc > 2) continue;
          if (int'(c) + wc < 2) continue;
          if (!win[wr * 3 + wc]) kept = 1'b0;
        end
      end
    end
    res.out_row        = POS_W'(int'(r) - 1);
    res.out_column     = POS_W'(int'(c) + k - 2);
    res.binary_pixel   = centre ? PIX_WHITE : PIX_BLACK;
    res.eroded_pixel   = kept ? PIX_WHITE : PIX_BLACK;
    res.boundary_pixel = res.binary_pixel - res.eroded_pixel;
    res.last_of_run    = 1'b0;
    res.end_of_frame   = 1'b0;
    return res;
  endfunction

  function automatic int field_differs(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want == got) return 0;
    $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : track
    result_t got;
    result_t want;
    result_t lag_res;
    result_t rim_res;
    logic    pix_white;
    logic    above;
    logic    mid;
    int      bad;
    if (!rst_n) begin
      grey_threshold = THRESHOLD_RESET;
      line_older     = '1;
      line_newer     = '1;
      window         = '1;
      raster_row     = '0;
      raster_col     = '0;
      boundary_due.delete();
      error_count     <= 0;
      results_due     <= 0;
      results_checked <= 0;
      frames_done     <= 0;
    end else begin
      bad = 0;

      // Compare an accepted result item with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got.out_row        = out_tdata[ROW_LSB +: POS_W];
        got.out_column     = out_tdata[COL_LSB +: POS_W];
        got.binary_pixel   = out_tdata[BIN_LSB +: PIX_W];
        got.eroded_pixel   = out_tdata[ERO_LSB +: PIX_W];
        got.boundary_pixel = out_tdata[BND_LSB +: PIX_W];
        got.last_of_run    = out_tlast;
        got.end_of_frame   = out_tuser;
        if (boundary_due.size() == 0) begin
          $error("result item for row %0d column %0d arrived with none expected",
                 got.out_row, got.out_column);
          bad++;
        end else begin
          want = boundary_due.pop_front();
          bad += field_differs("out_row", want.out_row, got.out_row);
          bad += field_differs("out_column", want.out_column, got.out_column);
          bad += field_differs("binary_pixel", want.binary_pixel, got.binary_pixel);
          bad += field_differs("eroded_pixel", want.eroded_pixel, got.eroded_pixel);
          bad += field_differs("boundary_pixel", want.boundary_pixel,
                               got.boundary_pixel);
          bad += field_differs("last_of_run", want.last_of_run, got.last_of_run);
          bad += field_differs("end_of_frame", want.end_of_frame, got.end_of_frame);
        end
        results_checked <= results_checked + 1;
        if (got.end_of_frame) frames_done <= frames_done + 1;
      end

      // Threshold the accepted pixel item, shift the window and predict.
      if (in_tvalid && in_tready) begin
        if (raster_row >= ROW_FLUSH || in_tuser) begin
          pix_white = 1'b1;
        end else begin
          pix_white = (in_tdata[PIX_W-1:0] >= grey_threshold);
        end
        above = line_older[raster_col];
        mid   = line_newer[raster_col];
        window = {pix_white, window[8:7], mid, window[5:4], above, window[2:1]};
        line_older[raster_col] = mid;
        line_newer[raster_col] = pix_white;

        if (raster_row != 0) begin
          if (raster_col == COL_LAST) begin
            // A row-end item also gives the result for the last column.
            lag_res = erode_centre(window, raster_row, raster_col, CENTRE_LAG);
            boundary_due.push_back(lag_res);
            rim_res = erode_centre(window, raster_row, raster_col, CENTRE_EDGE);
            rim_res.end_of_frame = (raster_row == ROW_FLUSH);
            rim_res.last_of_run  = 1'b1;
            boundary_due.push_back(rim_res);
          end else if (raster_col != 0) begin
            lag_res = erode_centre(window, raster_row, raster_col, CENTRE_LAG);
            lag_res.last_of_run = 1'b1;
            boundary_due.push_back(lag_res);
          end
        end

        // Advance the raster position; the flush row wraps to the next frame.
        if (raster_col == COL_LAST) begin
          raster_col = '0;
          raster_row = (raster_row >= ROW_FLUSH) ? '0 : raster_row + 1'b1;
        end else begin
          raster_col = raster_col + 1'b1;
        end
      end

      // Register writes only take the low byte as the threshold.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD) begin
        grey_threshold = cfg_pwdata[PIX_W-1:0];
      end

      error_count <= error_count + bad;
      results_due <= boundary_due.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the erosion boundary block through the first rows of a frame, across
// two row ends, so that the single and the paired result items both appear.
// Pixel items follow a blocky pattern with noise so that both solid interiors
// and edges appear. Between phases the threshold is rewritten, the extremes
// among the values. The checker beside the block predicts and compares every
// result item; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  import bebe_pkg::*;

  localparam int TOTAL_ITEMS    = 1350;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 600;
  localparam int DIRECTED_N     = 24;

  // Opening items as {is_padding, pixel_in}: grey extremes, values around the
  // reset threshold and padding inside the frame.
  localparam logic [8:0] OPENING [DIRECTED_N] = '{
    9'h000, 9'h0FF, 9'h07C, 9'h07D, 9'h07E, 9'h07C, 9'h07D, 9'h000,
    9'h0FF, 9'h100, 9'h1FF, 9'h17C, 9'h07D, 9'h001, 9'h0FE, 9'h080,
    9'h07F, 9'h055, 9'h0AA, 9'h100, 9'h000, 9'h0FF, 9'h0FF, 9'h000
  };

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic [IN_TDATA_W-1:0]   in_tdata    = '0;
  logic                    in_tuser    = 1'b0;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]   cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  int error_count;
  int results_due;
  int results_checked;
  int frames_done;

  int               items_sent   = 0;
  int               stall_cycles = 0;
  bit               idling       = 1'b0;
  logic [PIX_W-1:0] grey_thr     = THRESHOLD_RESET;
  logic [PIX_W-1:0] mid_thr      = '0;
  int               blk_w        = 4;
  int               blk_h        = 3;
  int               pos_row      = 0;
  int               pos_col      = 0;

  always #4 clk = ~clk;

  binary_erosion_boundary_extract i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  boundary_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .error_count     (error_count),
    .results_due     (results_due),
    .results_checked (results_checked),
    .frames_done     (frames_done)
  );

  // Offer one pixel item and wait for the edge that accepts it.
  task automatic send_item(input logic [PIX_W-1:0] grey, input logic pad);
    in_tdata  <= grey;
    in_tuser  <= pad;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (pos_col == IMAGE_WIDTH - 1) begin
      pos_col = 0;
      pos_row = (pos_row == IMAGE_HEIGHT) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endtask

  // Grey level from a checkerboard of blocks, with noise and values that sit
  // exactly on the threshold or just below it.
  function automatic logic [PIX_W-1:0] next_grey();
    int   sel;
    logic white;
    sel   = $urandom_range(0, 15);
    white = (((pos_col / blk_w) + (pos_row / blk_h)) % 2) == 1;
    if (sel == 0) return PIX_W'($urandom_range(0, 255));
    if (sel == 1) return grey_thr;
    if (sel == 2) return grey_thr - 1'b1;
    if (white || grey_thr == 0) return PIX_W'($urandom_range(grey_thr, 255));
    return PIX_W'($urandom_range(0, grey_thr - 1));
  endfunction

  // Random pixel items; the block pattern changes at the start of each phase and every sixteen rows.
  task automatic run_phase(input int count, input bit idle);
    int i;
    idling = idle;
    for (i = 0; i < count; i++) begin
      if (i == 0 || (pos_col == 0 && pos_row % 16 == 0)) begin
        blk_w = $urandom_range(2, 12);
        blk_h = $urandom_range(2, 8);
      end
      send_item(next_grey(), $urandom_range(0, 31) == 0);
      if (idle && $urandom_range(0, 4) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every predicted result item has come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the threshold register once the block has gone quiet.
  task automatic change_threshold(input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_THRESHOLD, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    grey_thr = value[PIX_W-1:0];
  endtask

  // Result side: ready in random bursts, short stalls while idling is on and
  // one long hold-off that fills the block and stalls its input.
  initial begin : receiver
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // End the run if no item moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening items at the reset threshold, then random items.
    idling = 1'b1;
    for (i = 0; i < DIRECTED_N; i++) begin
      send_item(OPENING[i][PIX_W-1:0], OPENING[i][8]);
    end
    run_phase(400, 1'b1);

    // Threshold extremes, a random level with junk above the low byte.
    change_threshold(32'h0000_0000);
    run_phase(250, 1'b1);
    change_threshold(32'h0000_00FF);
    run_phase(250, 1'b1);
    mid_thr = PIX_W'($urandom_range(1, 254));
    change_threshold({24'($urandom()), mid_thr});
    run_phase(250, 1'b1);

    // Last stretch at a fourth threshold, without idling.
    change_threshold(32'hA5A5_5A80);
    run_phase(TOTAL_ITEMS - items_sent, 1'b0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d pixel items sent, %0d result items checked, %0d frame end(s).",
             items_sent, results_checked, frames_done);
    $display("Thresholds 125, 0, 255, %0d and 128; one output hold-off of %0d cycles.",
             mid_thr, HOLD_CYCLES);
    if (error_count == 0 && results_due == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
